FILE: sv/cartridge_bank_mapper_chr_mirroring_defines.svh
// Assertion macros for the cartridge bank mapper.
`ifndef CARTRIDGE_BANK_MAPPER_CHR_MIRRORING_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_CHR_MIRRORING_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CBM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CBM_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define CBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: sv/cbm_pkg.sv
`default_nettype none

package cbm_pkg;

  localparam logic [15:0] CHR_ADDR_FIRST = 16'h7EF0;
  localparam logic [15:0] CHR_ADDR_2K_LAST = 16'h7EF1;
  localparam logic [15:0] CHR_ADDR_LAST = 16'h7EF5;
  localparam logic [15:0] PRG_ADDR_FIRST = 16'h7EFA;
  localparam logic [15:0] PRG_ADDR_LAST = 16'h7EFF;
  localparam logic [15:0] PATTERN_SPACE_END = 16'h2000;

  localparam logic KIND_CPU_WRITE = 1'b0;
  localparam logic KIND_VIDEO = 1'b1;

  localparam int MOD_STEPS = 8;
  localparam int STEP_W = $clog2(MOD_STEPS);
  localparam int DIV_W = 11;   // 8 * 255 = 2040

  // register map (byte offset bit 2 selects)
  localparam logic REG_CHR_UNITS = 1'b0;
  localparam logic REG_PRG_UNITS = 1'b1;
  localparam int PADDR_W = 3;

  localparam logic [7:0] CHR_UNITS_RST = 8'd16;
  localparam logic [7:0] PRG_UNITS_RST = 8'd8;
  localparam logic [8:0] PRG_HIGH_RST = 9'd14;

  typedef struct packed {
    logic        kind;
    logic [15:0] addr;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic       nametable_page;
    logic       nametable_update;
    logic [7:0] pattern_page;
    logic [8:0] prg_page_low;
    logic [8:0] prg_page_mid;
    logic [8:0] prg_page_high;
  } result_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_mod;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: sv/cbm_ctrl.sv
`default_nettype none

module cbm_ctrl (
  input  wire          clk,
  input  wire          rst,
  input  wire          item_valid,
  output logic         item_ready,
  input  cbm_pkg::sts_t sts,
  output cbm_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FINISH
  } state_t;

  state_t state;
  logic [cbm_pkg::STEP_W-1:0] cnt;

  // no transfer is taken while reset is held
  assign item_ready = (state == ST_IDLE) && !rst;

  always_comb begin
    cmd.load   = item_ready && item_valid;
    cmd.step   = (state == ST_CALC);
    cmd.commit = (state == ST_FINISH) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (item_valid) begin
            state <= sts.need_mod ? ST_CALC : ST_FINISH;
          end
        end
        ST_CALC: begin
          cnt <= cnt + 1'b1;
          if (cnt == cbm_pkg::STEP_W'(cbm_pkg::MOD_STEPS - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (sts.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/cbm_datapath.sv
`default_nettype none

module cbm_datapath (
  input  wire                  clk,
  input  wire                  rst,
  input  wire [7:0]            chr_units,
  input  wire [7:0]            prg_units,
  input  cbm_pkg::item_t       item,
  input  cbm_pkg::cmd_t        cmd,
  output cbm_pkg::sts_t        sts,
  output logic                 result_valid,
  input  wire                  result_ready,
  output cbm_pkg::result_t     result
);

  localparam int DW = cbm_pkg::DIV_W;

  // latched item and modulo unit
  cbm_pkg::item_t item_q;
  logic [DW-1:0]  div;
  logic [DW-1:0]  rem;
  logic [7:0]     dvd;

  // mapper state
  logic [7:0] slot_bits;
  logic [7:0] pat_bank [8];
  logic [8:0] prg_bank [3];
  logic [2:0] last_slot;
  logic       cur_screen;
  logic       screen_known;

  logic [7:0] slot_bits_next;
  logic [7:0] pat_bank_next [8];
  logic [8:0] prg_bank_next [3];
  logic [2:0] last_slot_next;
  logic       cur_screen_next;
  logic       screen_known_next;
  cbm_pkg::result_t res_next;

  logic in_chr, in_prg, q_chr, q_prg, q_video;
  logic [DW:0]   trial;
  logic [DW:0]   div_ext;
  logic [7:0]    chr_page, chr_inc, chr_page1;
  logic [8:0]    prg_page;
  logic [2:0]    s_a, s_b;
  logic [3:0]    prg_off;
  logic [1:0]    prg_idx;

  assign in_chr = (item.kind == cbm_pkg::KIND_CPU_WRITE) &&
                  (item.addr >= cbm_pkg::CHR_ADDR_FIRST) &&
                  (item.addr <= cbm_pkg::CHR_ADDR_LAST);
  assign in_prg = (item.kind == cbm_pkg::KIND_CPU_WRITE) &&
                  (item.addr >= cbm_pkg::PRG_ADDR_FIRST) &&
                  (item.addr <= cbm_pkg::PRG_ADDR_LAST);

  assign q_chr = (item_q.kind == cbm_pkg::KIND_CPU_WRITE) &&
                 (item_q.addr >= cbm_pkg::CHR_ADDR_FIRST) &&
                 (item_q.addr <= cbm_pkg::CHR_ADDR_LAST);
  assign q_prg = (item_q.kind == cbm_pkg::KIND_CPU_WRITE) &&
                 (item_q.addr >= cbm_pkg::PRG_ADDR_FIRST) &&
                 (item_q.addr <= cbm_pkg::PRG_ADDR_LAST);
  assign q_video = (item_q.kind == cbm_pkg::KIND_VIDEO) &&
                   (item_q.addr < cbm_pkg::PATTERN_SPACE_END);

  assign sts.need_mod = in_chr || in_prg;
  assign sts.out_free = !result_valid || result_ready;

  // restoring remainder, one dividend bit per step
  assign div_ext = {1'b0, div};
  assign trial   = {rem, dvd[7]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
      rem    <= '0;
      if (in_chr) begin
        div <= {chr_units, 3'b000};
        dvd <= {1'b0, item.data[6:0]};
      end else begin
        div <= {2'b00, prg_units, 1'b0};
        dvd <= item.data;
      end
    end else if (cmd.step) begin
      dvd <= {dvd[6:0], 1'b0};
      if (trial >= div_ext) begin
        rem <= DW'(trial - div_ext);
      end else begin
        rem <= trial[DW-1:0];
      end
    end
  end

  // zero page count maps everything to page 0
  assign chr_page  = (div == '0) ? 8'd0 : rem[7:0];
  assign chr_inc   = chr_page + 8'd1;
  assign chr_page1 = ((div == '0) || ({3'b000, chr_inc} == div)) ? 8'd0 : chr_inc;
  assign prg_page  = (div == '0) ? 9'd0 : {1'b0, rem[7:0]};
  assign prg_off   = item_q.addr[3:0] - cbm_pkg::PRG_ADDR_FIRST[3:0];
  assign prg_idx   = prg_off[2:1];

  always_comb begin
    slot_bits_next    = slot_bits;
    pat_bank_next     = pat_bank;
    prg_bank_next     = prg_bank;
    last_slot_next    = last_slot;
    cur_screen_next   = cur_screen;
    screen_known_next = screen_known;
    s_a               = '0;
    s_b               = '0;
    res_next          = '0;

    if (q_chr) begin
      if (item_q.addr <= cbm_pkg::CHR_ADDR_2K_LAST) begin
        s_a = {1'b0, item_q.addr[0], 1'b0};
        s_b = {1'b0, item_q.addr[0], 1'b1};
        slot_bits_next[s_a] = item_q.data[7];
        slot_bits_next[s_b] = item_q.data[7];
        pat_bank_next[s_a]  = chr_page;
        pat_bank_next[s_b]  = chr_page1;
      end else begin
        s_a = item_q.addr[2:0] + 3'd2;
        slot_bits_next[s_a] = item_q.data[7];
        pat_bank_next[s_a]  = chr_page;
      end
      cur_screen_next   = slot_bits_next[last_slot];
      screen_known_next = 1'b1;
      res_next.nametable_update = 1'b1;
    end else if (q_prg) begin
      prg_bank_next[prg_idx] = prg_page;
    end else if (q_video) begin
      s_a            = item_q.addr[12:10];
      last_slot_next = s_a;
      if (!screen_known || (slot_bits[s_a] != cur_screen)) begin
        cur_screen_next   = slot_bits[s_a];
        screen_known_next = 1'b1;
        res_next.nametable_update = 1'b1;
      end
      res_next.pattern_page = pat_bank[s_a];
    end

    res_next.nametable_page = cur_screen_next;
    res_next.prg_page_low   = prg_bank_next[0];
    res_next.prg_page_mid   = prg_bank_next[1];
    res_next.prg_page_high  = prg_bank_next[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_bits    <= '0;
      last_slot    <= '0;
      cur_screen   <= 1'b0;
      screen_known <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        pat_bank[i] <= 8'(i);
      end
      prg_bank[0]  <= 9'd0;
      prg_bank[1]  <= 9'd1;
      prg_bank[2]  <= cbm_pkg::PRG_HIGH_RST;
      result_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        slot_bits    <= slot_bits_next;
        pat_bank     <= pat_bank_next;
        prg_bank     <= prg_bank_next;
        last_slot    <= last_slot_next;
        cur_screen   <= cur_screen_next;
        screen_known <= screen_known_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result <= res_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/cartridge_bank_mapper_chr_mirroring.sv
`default_nettype none

// Bank mapper for a game cartridge with per-slot single-screen nametable
// select. Each item is one transfer on the item channel: a CPU write to the
// mapper registers (kind 0) or a video pattern fetch (kind 1). Every item
// gives exactly one transfer on the result channel carrying the nametable
// page, an update flag, the 1KB pattern page of the fetched slot and the three
// switchable 8KB program pages. Pattern and program bank writes reduce the
// written page modulo the ROM page count with a restoring remainder unit that
// takes one dividend bit per cycle, so a bank write passes through accept,
// 8 remainder steps and commit; every other item goes straight to commit.
// One item is in flight at a time; the result sits in an output register, so
// the next item is accepted while an earlier result still waits to be taken.
// ROM sizes are set over the APB port: offset 0x0 holds the pattern ROM size
// in 8KB units, offset 0x4 the program ROM size in 16KB units; write them only
// while the block is idle. A size of 0 maps every bank write of that kind to
// page 0.

`include "cartridge_bank_mapper_chr_mirroring_defines.svh"

module cartridge_bank_mapper_chr_mirroring (
  input  wire                          clk,
  input  wire                          rst,
  // config port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [cbm_pkg::PADDR_W-1:0]   paddr,
  input  wire [31:0]                   pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // item channel
  input  wire                          item_valid,
  output logic                         item_ready,
  input  cbm_pkg::item_t               item,
  // result channel
  output logic                         result_valid,
  input  wire                          result_ready,
  output cbm_pkg::result_t             result
);

  logic [7:0] chr_units;
  logic [7:0] prg_units;
  logic       cfg_wr;

  cbm_pkg::cmd_t cmd;
  cbm_pkg::sts_t sts;

  // APB: zero wait states; byte offset bits ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      chr_units <= cbm_pkg::CHR_UNITS_RST;
      prg_units <= cbm_pkg::PRG_UNITS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        cbm_pkg::REG_CHR_UNITS: chr_units <= pwdata[7:0];
        cbm_pkg::REG_PRG_UNITS: prg_units <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      cbm_pkg::REG_CHR_UNITS: prdata = {24'd0, chr_units};
      cbm_pkg::REG_PRG_UNITS: prdata = {24'd0, prg_units};
      default:                prdata = '0;
    endcase
  end

  // sequencer: accept, remainder steps for bank writes, commit
  cbm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // bank state, remainder unit and result register
  cbm_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .chr_units    (chr_units),
    .prg_units    (prg_units),
    .item         (item),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // a commit only lands when the result register can take it
  `CBM_ASSERT_IMPL(a_commit_free, clk, rst, cmd.commit, sts.out_free, "commit with result register full")
  // commit always leaves a result pending
  `CBM_ASSERT_NEXT(a_commit_valid, clk, rst, cmd.commit, result_valid, "commit did not present a result")
  // one item at a time: busy right after an accepted transfer
  `CBM_ASSERT_NEXT(a_busy_after_accept, clk, rst, item_valid && item_ready, !item_ready, "item accepted while busy")

endmodule

`default_nettype wire
